// ===== rtl/bmc_pkg.sv =====
// Types, codes and the duty table shared by the mode cycler files.
`default_nettype none

package bmc_pkg;

	typedef enum logic [1:0] {
		KIND_TICK    = 2'd0,
		KIND_LEVEL   = 2'd1,
		KIND_RESTORE = 2'd2
	} kind_t;

	typedef enum logic {
		REG_DEBOUNCE = 1'b0,
		REG_TIMEOUT  = 1'b1
	} reg_idx_t;

	localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
	localparam logic [15:0] TIMEOUT_RESET  = 16'd5000;

	localparam logic [7:0] DUTY_TABLE [8] = '{
		8'd255, 8'd127, 8'd63, 8'd31, 8'd15, 8'd7, 8'd3, 8'd1
	};

	typedef struct packed {
		kind_t       kind;
		logic        button_level;
		logic [15:0] stored_word;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  duty;
		logic [2:0]  current_mode;
		logic [15:0] save_word;
		logic        save_strobe;
		logic        press_active;
	} out_item_t;

	typedef struct packed {
		logic [15:0] debounce_ticks;
		logic [15:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic        last_level;
		logic        timing;
		logic [15:0] elapsed;
		logic [2:0]  mode;
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/bmc_stream_if.sv =====
// Valid/ready channel carrying one item.
`default_nettype none

interface bmc_stream_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

// ===== rtl/bmc_step.sv =====
// Next-state and result logic for one item of the mode cycler.
`default_nettype none

module bmc_step
	import bmc_pkg::*;
#(
	parameter int NUM_MODES = 8
) (
	input  wire in_item_t  item,
	input  wire state_t    cur,
	input  wire cfg_t      cfg,
	output state_t         nxt,
	output out_item_t      result
);

	localparam logic [3:0] MODE_LIMIT = 4'(NUM_MODES);

	logic [3:0]  mode_inc;
	logic [2:0]  mode_adv;
	logic [7:0]  word_lo;
	logic [7:0]  word_hi;
	logic        restore_ok;
	logic [15:0] elapsed_inc;
	logic        strobe;

	assign mode_inc    = {1'b0, cur.mode} + 4'd1;
	assign mode_adv    = (mode_inc >= MODE_LIMIT) ? 3'd0 : mode_inc[2:0];
	assign word_lo     = item.stored_word[7:0];
	assign word_hi     = item.stored_word[15:8];
	assign restore_ok  = (word_hi == ~word_lo) && (word_lo < {4'd0, MODE_LIMIT});
	assign elapsed_inc = cur.elapsed + 16'd1;

	always_comb begin
		nxt    = cur;
		strobe = 1'b0;
		case (item.kind)
			KIND_TICK: begin
				if (cur.timing) begin
					nxt.elapsed = elapsed_inc;
					if (elapsed_inc == cfg.timeout_ticks) begin
						nxt.timing  = 1'b0;
						nxt.elapsed = '0;
					end
				end
			end
			KIND_LEVEL: begin
				if (item.button_level != cur.last_level) begin
					nxt.last_level = item.button_level;
					nxt.elapsed    = '0;
					if (item.button_level) begin
						if (cur.timing) begin
							if (cur.elapsed >= cfg.debounce_ticks) begin
								nxt.mode = mode_adv;
								strobe   = 1'b1;
							end
							nxt.timing = 1'b0;
						end
					end else begin
						nxt.timing = 1'b1;
					end
				end
			end
			KIND_RESTORE: begin
				nxt.mode = restore_ok ? word_lo[2:0] : 3'd0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		result.duty         = DUTY_TABLE[nxt.mode];
		result.current_mode = nxt.mode;
		result.save_word    = {~{5'd0, nxt.mode}, {5'd0, nxt.mode}};
		result.save_strobe  = strobe;
		result.press_active = nxt.timing;
	end

endmodule

`default_nettype wire

// ===== rtl/button_mode_cycler_pwm_level.sv =====
// Top level: button press qualifier cycling a brightness mode with PWM duty lookup.
//
//  channel | dir | payload                                          | handshake
//  evt     | in  | kind, button_level, stored_word                  | valid/ready
//  res     | out | duty, current_mode, save_word, save_strobe,      | valid/ready
//          |     | press_active                                     |
//  cfg     | in  | cfg_index, cfg_data                              | cfg_wen
//
// One item per cycle while res is not stalled; each item passes the input register, then the result register.
// The state update sits between the two registers, so the next item sees it at once.
// Reset: released level, no press timed, elapsed 0, mode 0, debounce 50, timeout 5000.
// A stall on res holds the result register and the input register; evt.ready
// drops only when both are full and res is not taken.
`default_nettype none

module button_mode_cycler_pwm_level
	import bmc_pkg::*;
#(
	parameter int NUM_MODES = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	bmc_stream_if.sink  evt,
	bmc_stream_if.source res,
	input  wire         cfg_wen,
	input  wire         cfg_index,
	input  wire  [15:0] cfg_data
);

	cfg_t      cfg_q;
	state_t    state_q;
	state_t    state_nxt;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_q;
	logic      res_valid_q;
	out_item_t step_res;
	logic      load_out;
	logic      adv_s1;

	assign load_out  = !res_valid_q || res.ready;
	assign adv_s1    = valid_s1 && load_out;
	assign evt.ready = !valid_s1 || load_out;
	assign res.valid = res_valid_q;
	assign res.item  = res_q;

	bmc_step #(
		.NUM_MODES (NUM_MODES)
	) u_step (
		.item   (item_s1),
		.cur    (state_q),
		.cfg    (cfg_q),
		.nxt    (state_nxt),
		.result (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= DEBOUNCE_RESET;
			cfg_q.timeout_ticks  <= TIMEOUT_RESET;
		end else if (cfg_wen) begin
			case (reg_idx_t'(cfg_index))
				REG_DEBOUNCE: cfg_q.debounce_ticks <= cfg_data;
				REG_TIMEOUT:  cfg_q.timeout_ticks  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			item_s1 <= evt.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.last_level <= 1'b1;
			state_q.timing     <= 1'b0;
			state_q.elapsed    <= '0;
			state_q.mode       <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= step_res;
		end
	end

	a_idle_elapsed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.timing |-> (state_q.elapsed == 16'd0))
		else $error("elapsed nonzero while no press is timed");

	a_timing_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.timing |-> !state_q.last_level)
		else $error("press timed while level is released");

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, state_q.mode} < 4'(NUM_MODES)))
		else $error("mode out of range");

	a_strobe_ends_press: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.save_strobe) |-> !res_q.press_active)
		else $error("save strobe with press still active");

endmodule

`default_nettype wire

// ===== tb/button_mode_cycler_pwm_level_tb.sv =====
// Testbench for button_mode_cycler_pwm_level: random and directed items checked by a predictor.
`timescale 1ns / 1ps

module button_mode_cycler_pwm_level_tb;
	import bmc_pkg::*;

	localparam int NUM_MODES = 8;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 80;
	localparam int REPORT_CAP = 20;

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	reg_idx_t    cfg_index;
	logic [15:0] cfg_data;

	bmc_stream_if #(.item_t(in_item_t))  evt_if ();
	bmc_stream_if #(.item_t(out_item_t)) res_if ();

	button_mode_cycler_pwm_level #(.NUM_MODES(NUM_MODES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt_if),
		.res(res_if),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state and register copies
	logic        level_m;
	logic        timing_m;
	logic [15:0] elapsed_m;
	logic [2:0]  mode_m;
	logic [15:0] debounce_m;
	logic [15:0] timeout_m;

	in_item_t  pending_items[$];
	out_item_t lamp_results_due[$];
	int        outstanding;
	int        fail_count;
	int        idle_cycles;
	int        hold_left;
	bit        hold_request;
	bit        steady;
	bit        evt_sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic out_item_t step_lamp(in_item_t it);
		out_item_t r;
		logic      strobe;
		strobe = 1'b0;
		case (it.kind)
			KIND_TICK: begin
				if (timing_m) begin
					elapsed_m = elapsed_m + 16'd1;
					if (elapsed_m == timeout_m) begin
						timing_m = 1'b0;
						elapsed_m = '0;
					end
				end
			end
			KIND_LEVEL: begin
				if (it.button_level != level_m) begin
					level_m = it.button_level;
					if (it.button_level) begin
						if (timing_m) begin
							if (elapsed_m >= debounce_m) begin
								mode_m = (int'(mode_m) + 1 >= NUM_MODES) ? 3'd0 : mode_m + 3'd1;
								strobe = 1'b1;
							end
							timing_m = 1'b0;
						end
						elapsed_m = '0;
					end else begin
						elapsed_m = '0;
						timing_m = 1'b1;
					end
				end
			end
			KIND_RESTORE: begin
				if (it.stored_word[15:8] == ~it.stored_word[7:0]
						&& int'(it.stored_word[7:0]) < NUM_MODES)
					mode_m = it.stored_word[2:0];
				else
					mode_m = 3'd0;
			end
			default: ;
		endcase
		r.duty = 8'((16'd256 >> mode_m) - 16'd1);
		r.current_mode = mode_m;
		r.save_word = {~{5'd0, mode_m}, {5'd0, mode_m}};
		r.save_strobe = strobe;
		r.press_active = timing_m;
		return r;
	endfunction

	task automatic report_field(string name, int exp_v, int act_v);
		fail_count++;
		if (fail_count <= REPORT_CAP)
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
	endtask

	// input driver
	always @(negedge clk) begin
		if (!evt_if.valid || evt_sent) begin
			if (pending_items.size() > 0 && (steady || $urandom_range(0, 99) >= 18)) begin
				evt_if.item <= pending_items.pop_front();
				evt_if.valid <= 1'b1;
			end else begin
				evt_if.valid <= 1'b0;
			end
		end
		evt_sent = 1'b0;
	end

	// result receiver
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= arst_n && (steady || $urandom_range(0, 99) >= 18);
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		out_item_t due;
		bit        moved;
		moved = 1'b0;
		if (arst_n) begin
			if (evt_if.valid && evt_if.ready) begin
				lamp_results_due.push_back(step_lamp(evt_if.item));
				evt_sent = 1'b1;
				moved = 1'b1;
			end
			if (res_if.valid && res_if.ready) begin
				moved = 1'b1;
				if (lamp_results_due.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_CAP)
						$display("%0t: result with none expected, expected none, actual %h",
							$time, res_if.item);
				end else begin
					due = lamp_results_due.pop_front();
					outstanding--;
					if (res_if.item.duty !== due.duty)
						report_field("duty", due.duty, res_if.item.duty);
					if (res_if.item.current_mode !== due.current_mode)
						report_field("current_mode", due.current_mode, res_if.item.current_mode);
					if (res_if.item.save_word !== due.save_word)
						report_field("save_word", due.save_word, res_if.item.save_word);
					if (res_if.item.save_strobe !== due.save_strobe)
						report_field("save_strobe", due.save_strobe, res_if.item.save_strobe);
					if (res_if.item.press_active !== due.press_active)
						report_field("press_active", due.press_active, res_if.item.press_active);
				end
			end
		end
		if (moved)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic queue_item(kind_t k, logic lvl, logic [15:0] w);
		in_item_t it;
		it.kind = k;
		it.button_level = lvl;
		it.stored_word = w;
		pending_items.push_back(it);
		outstanding++;
	endtask

	task automatic queue_tick();
		queue_item(KIND_TICK, 1'($urandom), 16'($urandom));
	endtask

	task automatic queue_level(logic lvl);
		queue_item(KIND_LEVEL, lvl, 16'($urandom));
	endtask

	task automatic queue_restore(logic [15:0] w);
		queue_item(KIND_RESTORE, 1'($urandom), w);
	endtask

	task automatic hold_press(int ticks, bit let_go);
		queue_level(1'b0);
		for (int i = 0; i < ticks; i++)
			queue_tick();
		if (let_go)
			queue_level(1'b1);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wen <= 1'b0;
		if (idx == REG_DEBOUNCE)
			debounce_m = val;
		else
			timeout_m = val;
	endtask

	task automatic settle();
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic queue_random(int count);
		int          n;
		int          span;
		int          cap;
		int          pick;
		logic [2:0]  m;
		logic [15:0] w;
		n = 0;
		cap = ((debounce_m > timeout_m) ? int'(debounce_m) : int'(timeout_m)) + 2;
		if (cap > 80)
			cap = 80;
		while (n < count) begin
			if ($urandom_range(0, 99) < 70) begin
				span = $urandom_range(0, cap);
				queue_level(1'b0);
				n++;
				for (int i = 0; i < span; i++) begin
					if ($urandom_range(0, 19) == 0) begin
						m = 3'($urandom);
						queue_restore({~{5'd0, m}, {5'd0, m}});
						n++;
					end
					queue_tick();
					n++;
				end
				if ($urandom_range(0, 9) != 0) begin
					queue_level(1'b1);
					n++;
				end
			end else begin
				pick = $urandom_range(0, 15);
				m = 3'($urandom);
				w = ($urandom_range(0, 1) == 0) ? {~{5'd0, m}, {5'd0, m}} : 16'($urandom);
				if (pick == 0)
					queue_item(kind_t'(KIND_UNUSED), 1'($urandom), w);
				else
					queue_item(kind_t'($urandom_range(0, 2)), 1'($urandom), w);
				n++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = REG_DEBOUNCE;
		cfg_data = '0;
		evt_if.valid = 1'b0;
		evt_if.item = '0;
		res_if.ready = 1'b0;
		level_m = 1'b1;
		timing_m = 1'b0;
		elapsed_m = '0;
		mode_m = '0;
		debounce_m = DEBOUNCE_RESET;
		timeout_m = TIMEOUT_RESET;
		outstanding = 0;
		fail_count = 0;
		idle_cycles = 0;
		hold_left = 0;
		hold_request = 1'b0;
		steady = 1'b0;
		evt_sent = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: short presses, timeout, restores, repeated levels
		write_reg(REG_DEBOUNCE, 16'd2);
		write_reg(REG_TIMEOUT, 16'd5);
		queue_tick();
		queue_level(1'b1);
		queue_level(1'b0);
		queue_level(1'b0);
		queue_tick();
		queue_level(1'b1);
		hold_press(2, 1'b1);
		hold_press(5, 1'b0);
		queue_level(1'b1);
		queue_restore(16'hF807);
		queue_restore(16'hF708);
		queue_restore(16'h00FF);
		queue_restore(16'h1234);
		queue_restore(16'hFF00);
		queue_restore(16'hF807);
		hold_press(3, 1'b1);
		queue_item(kind_t'(KIND_UNUSED), 1'b0, 16'hFFFF);
		queue_level(1'b0);
		queue_restore(16'hF906);
		queue_tick();
		queue_tick();
		queue_level(1'b1);
		settle();

		write_reg(REG_DEBOUNCE, 16'd0);
		write_reg(REG_TIMEOUT, 16'd1);
		hold_press(0, 1'b1);
		hold_press(1, 1'b1);
		queue_random(150);
		settle();

		write_reg(REG_DEBOUNCE, 16'd3);
		write_reg(REG_TIMEOUT, 16'd8);
		hold_request = 1'b1;
		queue_random(300);
		settle();

		// long presses at the debounce and timeout edges, no idling on either side
		steady = 1'b1;
		write_reg(REG_DEBOUNCE, 16'd60);
		write_reg(REG_TIMEOUT, 16'd61);
		hold_press(60, 1'b1);
		hold_press(61, 1'b0);
		queue_tick();
		queue_level(1'b1);
		settle();
		steady = 1'b0;

		write_reg(REG_DEBOUNCE, 16'($urandom_range(0, 10)));
		write_reg(REG_TIMEOUT, 16'($urandom_range(1, 15)));
		hold_request = 1'b1;
		queue_random(300);
		settle();

		write_reg(REG_DEBOUNCE, 16'hFFFF);
		write_reg(REG_TIMEOUT, 16'hFFFF);
		queue_random(100);
		settle();

		write_reg(REG_DEBOUNCE, DEBOUNCE_RESET);
		write_reg(REG_TIMEOUT, TIMEOUT_RESET);
		queue_random(250);
		settle();

		write_reg(REG_DEBOUNCE, 16'($urandom_range(0, 6)));
		write_reg(REG_TIMEOUT, 16'($urandom_range(1, 12)));
		queue_random(100);
		settle();

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
